>>> src/sac_pkg.sv
`timescale 1ns / 1ps
// sac_pkg: shared types, constants and helpers of the set-associative cache tag model
// no dependencies

package sac_pkg;

   localparam int ADDR_W        = 48;
   localparam int CNT_W         = 32;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 5;
   localparam int DEF_ADDR_BITS = 48;
   localparam int DEF_MAX_SETS  = 64;
   localparam int DEF_MAX_WAYS  = 8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BLOCK_LOG2 = 3'd0,
      CSR_CACHE_LOG2 = 3'd1,
      CSR_WAYS_LOG2  = 3'd2,
      CSR_REPL_LRU   = 3'd3,
      CSR_PREFETCH   = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ1,
      ST_UPD1,
      ST_UPD2,
      ST_DONE
   } state_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      sat_inc = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
   endfunction

endpackage

>>> src/sac_if.sv
`timescale 1ns / 1ps
// sac_req_if and sac_rsp_if: valid/ready channels for access words and result words
// depends on sac_pkg

interface sac_req_if;
   logic                       valid;
   logic                       ready;
   logic [sac_pkg::ADDR_W-1:0] address;
   logic                       is_write;
   modport source (output valid, address, is_write, input ready);
   modport sink   (input valid, address, is_write, output ready);
endinterface

interface sac_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      hit;
   logic                      prefetch_filled;
   logic [sac_pkg::CNT_W-1:0] hit_total;
   logic [sac_pkg::CNT_W-1:0] miss_total;
   logic [sac_pkg::CNT_W-1:0] read_total;
   logic [sac_pkg::CNT_W-1:0] write_total;
   modport source (output valid, hit, prefetch_filled, hit_total, miss_total, read_total,
                   write_total, input ready);
   modport sink   (input valid, hit, prefetch_filled, hit_total, miss_total, read_total,
                   write_total, output ready);
endinterface

>>> src/set_assoc_cache_prefetch.sv
`timescale 1ns / 1ps
// set_assoc_cache_prefetch: top level, control sequencer, geometry, counters, result register
// depends on sac_pkg, sac_if, sac_row_ram, sac_set_update

// Tag-only set-associative cache with FIFO or LRU replacement and optional next-line
// prefetch. Each set is one row of a synchronous memory; an access reads the row (ST_READ1),
// updates it and writes it back (ST_UPD1) and hands its result on (ST_DONE); the next access
// is taken once the block is back in ST_IDLE. A miss with prefetch adds ST_UPD2 after
// ST_UPD1: the second set read is issued in the cycle of the first write, with the updated
// row forwarded when both blocks share a set. After reset the block clears all MAX_SETS rows
// before it takes the first access; configuration writes are taken throughout. A result
// waiting in the output register does not block the next access from being accepted, but
// that access holds its result until the register is free.

module set_assoc_cache_prefetch #(
   parameter int ADDR_BITS = sac_pkg::DEF_ADDR_BITS,
   parameter int MAX_SETS  = sac_pkg::DEF_MAX_SETS,
   parameter int MAX_WAYS  = sac_pkg::DEF_MAX_WAYS
) (
   input  logic                            clock,
   input  logic                            reset,
   sac_req_if.sink                         req_if,
   sac_rsp_if.source                       rsp_if,
   input  logic                            csr_we,
   input  logic [sac_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sac_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import sac_pkg::*;

   localparam int RW  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int EW  = 1 + RW + ADDR_BITS;
   localparam int WC  = $clog2(MAX_WAYS + 1);
   localparam int SW  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int RWD = MAX_WAYS * EW;
   localparam int WL  = $clog2(MAX_WAYS + 1) - 1;
   localparam int SL  = $clog2(MAX_SETS + 1) - 1;

   state_type            state_ff, state_in;
   logic [SW-1:0]        clr_ff;
   logic [3:0]           blk_log2_ff;
   logic [4:0]           cache_log2_ff;
   logic [1:0]           ways_log2_ff;
   logic                 lru_ff, pf_ff;

   logic [SW-1:0]        set1_ff, set2_ff;
   logic [ADDR_BITS-1:0] tag1_ff, tag2_ff;
   logic [WC-1:0]        ways_used_ff;
   logic [RWD-1:0]       fwd_ff;
   logic                 res_hit_ff, res_fill_ff;
   logic [CNT_W-1:0]     hit_cnt_ff, miss_cnt_ff, read_cnt_ff, write_cnt_ff;

   logic                 rsp_valid_ff, rsp_hit_ff, rsp_fill_ff;
   logic [CNT_W-1:0]     rsp_hit_tot_ff, rsp_miss_tot_ff, rsp_read_tot_ff, rsp_write_tot_ff;

   logic                 accept, rsp_free;
   logic [4:0]           nb, w_eff, s_eff, w_tmp, s_tmp;
   logic [5:0]           tag_sh;
   logic [63:0]          addr_ext;
   logic [ADDR_BITS-1:0] a_cur, a_nxt, set_mask;

   logic                 mem_we, mem_re;
   logic [SW-1:0]        mem_waddr, mem_raddr;
   logic [RWD-1:0]       mem_wdata, mem_rdata;
   logic [RWD-1:0]       upd_row_in, upd_row_out;
   logic [ADDR_BITS-1:0] upd_tag;
   logic                 upd_hit;

   assign accept   = req_if.valid && req_if.ready;
   assign rsp_free = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = (state_ff == ST_IDLE);

   // geometry
   always_comb begin
      nb    = (cache_log2_ff >= {1'b0, blk_log2_ff}) ? cache_log2_ff - {1'b0, blk_log2_ff} : '0;
      w_tmp = ({3'b0, ways_log2_ff} > nb) ? nb : {3'b0, ways_log2_ff};
      w_eff = (w_tmp > 5'(WL)) ? 5'(WL) : w_tmp;
      s_tmp = nb - w_eff;
      s_eff = (s_tmp > 5'(SL)) ? 5'(SL) : s_tmp;
      tag_sh   = {2'b0, blk_log2_ff} + {1'b0, s_eff};
      addr_ext = 64'(req_if.address);
      a_cur    = addr_ext[ADDR_BITS-1:0] & ~((ADDR_BITS'(1) << blk_log2_ff) - ADDR_BITS'(1));
      a_nxt    = a_cur + (ADDR_BITS'(1) << blk_log2_ff);
      set_mask = (ADDR_BITS'(1) << s_eff) - ADDR_BITS'(1);
   end

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         blk_log2_ff   <= 4'd6;
         cache_log2_ff <= 5'd12;
         ways_log2_ff  <= 2'd1;
         lru_ff        <= 1'b1;
         pf_ff         <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BLOCK_LOG2: blk_log2_ff   <= csr_wdata[3:0];
            CSR_CACHE_LOG2: cache_log2_ff <= csr_wdata[4:0];
            CSR_WAYS_LOG2:  ways_log2_ff  <= csr_wdata[1:0];
            CSR_REPL_LRU:   lru_ff        <= csr_wdata[0];
            CSR_PREFETCH:   pf_ff         <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + SW'(1);
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      mem_we    = 1'b0;
      mem_waddr = set1_ff;
      mem_wdata = upd_row_out;
      mem_re    = 1'b0;
      mem_raddr = set1_ff;
      upd_row_in = mem_rdata;
      upd_tag    = tag1_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            if (clr_ff == SW'(MAX_SETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_READ1;
            end
         end
         ST_READ1: begin
            mem_re   = 1'b1;
            state_in = ST_UPD1;
         end
         ST_UPD1: begin
            mem_we = 1'b1;
            if (!upd_hit && pf_ff) begin
               mem_re    = 1'b1;
               mem_raddr = set2_ff;
               state_in  = ST_UPD2;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_UPD2: begin
            upd_tag    = tag2_ff;
            upd_row_in = (set2_ff == set1_ff) ? fwd_ff : mem_rdata;
            mem_we     = 1'b1;
            mem_waddr  = set2_ff;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // access registers and counters
   always_ff @(posedge clock) begin
      if (accept) begin
         set1_ff      <= SW'((a_cur >> blk_log2_ff) & set_mask);
         set2_ff      <= SW'((a_nxt >> blk_log2_ff) & set_mask);
         tag1_ff      <= a_cur >> tag_sh;
         tag2_ff      <= a_nxt >> tag_sh;
         ways_used_ff <= WC'(1) << w_eff;
      end
      if (state_ff == ST_UPD1) begin
         fwd_ff <= upd_row_out;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         read_cnt_ff  <= '0;
         write_cnt_ff <= '0;
         res_hit_ff   <= 1'b0;
         res_fill_ff  <= 1'b0;
      end else begin
         if (accept && req_if.is_write) begin
            write_cnt_ff <= sat_inc(write_cnt_ff);
         end
         if (state_ff == ST_UPD1) begin
            res_hit_ff  <= upd_hit;
            res_fill_ff <= 1'b0;
            if (upd_hit) begin
               hit_cnt_ff <= sat_inc(hit_cnt_ff);
            end else begin
               miss_cnt_ff <= sat_inc(miss_cnt_ff);
               read_cnt_ff <= sat_inc(read_cnt_ff);
            end
         end
         if (state_ff == ST_UPD2 && !upd_hit) begin
            res_fill_ff <= 1'b1;
            read_cnt_ff <= sat_inc(read_cnt_ff);
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_DONE && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_hit_ff       <= res_hit_ff;
         rsp_fill_ff      <= res_fill_ff;
         rsp_hit_tot_ff   <= hit_cnt_ff;
         rsp_miss_tot_ff  <= miss_cnt_ff;
         rsp_read_tot_ff  <= read_cnt_ff;
         rsp_write_tot_ff <= write_cnt_ff;
      end
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.hit             = rsp_hit_ff;
   assign rsp_if.prefetch_filled = rsp_fill_ff;
   assign rsp_if.hit_total       = rsp_hit_tot_ff;
   assign rsp_if.miss_total      = rsp_miss_tot_ff;
   assign rsp_if.read_total      = rsp_read_tot_ff;
   assign rsp_if.write_total     = rsp_write_tot_ff;

   sac_row_ram #(
      .DEPTH (MAX_SETS),
      .WIDTH (RWD)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   sac_set_update #(
      .ADDR_BITS (ADDR_BITS),
      .MAX_WAYS  (MAX_WAYS)
   ) u_upd (
      .row_in    (upd_row_in),
      .tag       (upd_tag),
      .ways_used (ways_used_ff),
      .lru       (lru_ff),
      .row_out   (upd_row_out),
      .hit       (upd_hit)
   );

   a_accept_reads: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_READ1)
      else $error("accepted word did not start a set read");

   a_fill_on_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_fill_ff |-> !rsp_hit_ff)
      else $error("prefetch fill reported on a hit");

   a_upd2_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_UPD2 |-> $past(state_ff) == ST_UPD1)
      else $error("prefetch update without demand update");

endmodule

>>> src/sac_row_ram.sv
`timescale 1ns / 1ps
// sac_row_ram: one-write one-read synchronous row memory, registered read data
// depends on sac_pkg

module sac_row_ram #(
   parameter int DEPTH = sac_pkg::DEF_MAX_SETS,
   parameter int WIDTH = 8
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic                                  re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);
   import sac_pkg::*;

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> src/sac_set_update.sv
`timescale 1ns / 1ps
// sac_set_update: lookup of one set row, recency refresh on hit in LRU mode, fill or replace on miss
// depends on sac_pkg

module sac_set_update #(
   parameter int ADDR_BITS = sac_pkg::DEF_ADDR_BITS,
   parameter int MAX_WAYS  = sac_pkg::DEF_MAX_WAYS,
   localparam int RW  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
   localparam int EW  = 1 + RW + ADDR_BITS,
   localparam int WC  = $clog2(MAX_WAYS + 1)
) (
   input  logic [MAX_WAYS*EW-1:0] row_in,
   input  logic [ADDR_BITS-1:0]   tag,
   input  logic [WC-1:0]          ways_used,
   input  logic                   lru,
   output logic [MAX_WAYS*EW-1:0] row_out,
   output logic                   hit
);
   import sac_pkg::*;

   localparam logic [RW-1:0] RMAX = RW'(MAX_WAYS - 1);

   logic                 en     [MAX_WAYS];
   logic                 vld    [MAX_WAYS];
   logic [RW-1:0]        rank   [MAX_WAYS];
   logic [ADDR_BITS-1:0] tg     [MAX_WAYS];
   logic                 n_vld  [MAX_WAYS];
   logic [RW-1:0]        n_rank [MAX_WAYS];
   logic [ADDR_BITS-1:0] n_tg   [MAX_WAYS];
   logic [RW-1:0]        hw, fw, vw, vic;
   logic [RW-1:0]        vmax, lim;
   logic                 free_found;

   always_comb begin
      for (int i = 0; i < MAX_WAYS; i++) begin
         en[i]   = WC'(i) < ways_used;
         vld[i]  = row_in[i*EW + RW + ADDR_BITS];
         rank[i] = row_in[i*EW + ADDR_BITS +: RW];
         tg[i]   = row_in[i*EW +: ADDR_BITS];
      end
      hit = 1'b0;
      hw  = '0;
      free_found = 1'b0;
      fw  = '0;
      for (int i = 0; i < MAX_WAYS; i++) begin
         if (en[i] && vld[i] && tg[i] == tag && !hit) begin
            hit = 1'b1;
            hw  = RW'(i);
         end
         if (en[i] && !vld[i] && !free_found) begin
            free_found = 1'b1;
            fw = RW'(i);
         end
      end
      vw   = '0;
      vmax = rank[0];
      for (int i = 1; i < MAX_WAYS; i++) begin
         if (en[i] && rank[i] > vmax) begin
            vw   = RW'(i);
            vmax = rank[i];
         end
      end
      for (int i = 0; i < MAX_WAYS; i++) begin
         n_vld[i]  = vld[i];
         n_rank[i] = rank[i];
         n_tg[i]   = tg[i];
      end
      lim = rank[hw];
      vic = free_found ? fw : vw;
      if (hit) begin
         if (lru) begin
            for (int i = 0; i < MAX_WAYS; i++) begin
               if (en[i] && vld[i] && rank[i] < lim && rank[i] < RMAX) begin
                  n_rank[i] = rank[i] + RW'(1);
               end
            end
            n_rank[hw] = '0;
         end
      end else begin
         n_vld[vic] = 1'b0;
         for (int i = 0; i < MAX_WAYS; i++) begin
            if (en[i] && n_vld[i] && rank[i] < RMAX) begin
               n_rank[i] = rank[i] + RW'(1);
            end
         end
         n_tg[vic]   = tag;
         n_vld[vic]  = 1'b1;
         n_rank[vic] = '0;
      end
      for (int i = 0; i < MAX_WAYS; i++) begin
         row_out[i*EW +: EW] = {n_vld[i], n_rank[i], n_tg[i]};
      end
   end

endmodule
